### design/abe_pkg.sv
// shared types and codes of the allocation bitmap engine
package abe_pkg;

  // operation codes
  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_TEST  = 3'd2;
  localparam logic [2:0] OP_FIRST = 3'd3;
  localparam logic [2:0] OP_HOLE  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  bit_index;
    logic [10:0] hole_length;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       bit_value;
    logic [9:0] found_index;
  } rsp_t;

  // outcome of request decode
  typedef enum logic [1:0] {
    DEC_DONE = 2'd0,
    DEC_BIT  = 2'd1,
    DEC_SCAN = 2'd2
  } dec_kind_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic decode;
    logic rmw;
    logic scan;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic      clr_last;
    dec_kind_t dec_kind;
    logic      scan_done;
    logic      out_room;
  } dp_stat_t;

endpackage

### design/abe_ram.sv
// generic single write port ram with registered read
module abe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/abe_datapath.sv
// datapath: size register, request register, bitmap ram, run counter, result registers
module abe_datapath #(
  parameter int MAX_BYTES = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data,
  input  abe_pkg::req_t    req,
  input  abe_pkg::ctl_cmd_t cmd,
  output abe_pkg::dp_stat_t stat,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output abe_pkg::rsp_t    rsp
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int UB_MAX = (MAX_BYTES > 255) ? 255 : MAX_BYTES;

  logic [7:0]          bytes_in_use;
  logic [7:0]          used;
  logic [10:0]         nbits;
  abe_pkg::req_t       req_q;
  logic [10:0]         target;
  abe_pkg::dec_kind_t  dec_kind;
  logic [1:0]          dec_status;
  logic                is_bitop;

  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       bit_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data;
  logic [7:0]          mask;

  logic [7:0]          chk_cnt;
  logic [8:0]          chk_next;
  logic [10:0]         run;
  logic [10:0]         run_v;
  logic                hit_v;
  logic [2:0]          pos_v;
  logic [10:0]         found_full;
  logic                scan_last;

  logic [1:0]          res_status;
  logic                res_value;
  logic [9:0]          res_found;

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= '0;
    end else if (cfg_write) begin
      bytes_in_use <= cfg_data;
    end
  end

  assign used  = (bytes_in_use > 8'(UB_MAX)) ? 8'(UB_MAX) : bytes_in_use;
  assign nbits = {used, 3'b000};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  // first free is a hole of length one
  assign target   = (req_q.operation == abe_pkg::OP_FIRST) ? 11'd1 : req_q.hole_length;
  assign is_bitop = (req_q.operation == abe_pkg::OP_SET) ||
                    (req_q.operation == abe_pkg::OP_CLEAR) ||
                    (req_q.operation == abe_pkg::OP_TEST);

  always_comb begin
    dec_kind   = abe_pkg::DEC_DONE;
    dec_status = abe_pkg::ST_OK;
    if (used == 8'd0) begin
      dec_status = abe_pkg::ST_ZERO;
    end else if (is_bitop) begin
      if ({1'b0, req_q.bit_index} >= nbits) begin
        dec_status = abe_pkg::ST_RANGE;
      end else begin
        dec_kind = abe_pkg::DEC_BIT;
      end
    end else if ((req_q.operation == abe_pkg::OP_FIRST) ||
                 (req_q.operation == abe_pkg::OP_HOLE)) begin
      if (target > nbits) begin
        dec_status = abe_pkg::ST_NONE;
      end else if (target != 11'd0) begin
        dec_kind = abe_pkg::DEC_SCAN;
      end
    end else begin
      dec_status = abe_pkg::ST_RANGE;
    end
  end

  // bitmap ram and its ports
  abe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign bit_addr = AW'(req_q.bit_index[9:3]);
  assign mask     = 8'd1 << req_q.bit_index[2:0];
  assign chk_next = {1'b0, chk_cnt} + 9'd1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.rmw && (req_q.operation != abe_pkg::OP_TEST)) begin
      wr_en   = 1'b1;
      wr_addr = bit_addr;
      wr_data = (req_q.operation == abe_pkg::OP_SET) ? (rd_data | mask) : (rd_data & ~mask);
    end
  end

  always_comb begin
    if (cmd.scan) begin
      rd_addr = (chk_next < {1'b0, used}) ? AW'(chk_next) : '0;
    end else if (dec_kind == abe_pkg::DEC_SCAN) begin
      rd_addr = '0;
    end else begin
      rd_addr = bit_addr;
    end
  end

  // run length over the eight bits of the byte in hand
  always_comb begin
    run_v = run;
    hit_v = 1'b0;
    pos_v = '0;
    for (int j = 0; j < 8; j++) begin
      if (!hit_v) begin
        run_v = rd_data[j] ? 11'd0 : run_v + 11'd1;
        if (run_v == target) begin
          hit_v = 1'b1;
          pos_v = 3'(j);
        end
      end
    end
  end

  assign found_full = {chk_cnt, pos_v} + 11'd1 - target;
  assign scan_last  = (chk_cnt == used - 8'd1);

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      chk_cnt <= '0;
      run     <= '0;
    end else if (cmd.scan) begin
      chk_cnt <= chk_next[7:0];
      run     <= run_v;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.decode && (dec_kind == abe_pkg::DEC_DONE)) begin
      res_status <= dec_status;
      res_value  <= 1'b0;
      res_found  <= '0;
    end else if (cmd.rmw) begin
      res_status <= abe_pkg::ST_OK;
      res_value  <= (req_q.operation == abe_pkg::OP_TEST) ?
                    rd_data[req_q.bit_index[2:0]] : 1'b0;
      res_found  <= '0;
    end else if (cmd.scan && (hit_v || scan_last)) begin
      res_status <= hit_v ? abe_pkg::ST_OK : abe_pkg::ST_NONE;
      res_value  <= 1'b0;
      res_found  <= hit_v ? found_full[9:0] : 10'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status      <= res_status;
      rsp.bit_value   <= res_value;
      rsp.found_index <= res_found;
    end
  end

  assign stat.clr_last  = (clr_addr == AW'(MAX_BYTES - 1));
  assign stat.dec_kind  = dec_kind;
  assign stat.scan_done = hit_v || scan_last;
  assign stat.out_room  = !rsp_valid || !rsp_stall;

endmodule

### design/abe_ctrl.sv
// controller state machine of the allocation bitmap engine
module abe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  abe_pkg::dp_stat_t stat,
  output abe_pkg::ctl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_RMW    = 6'b001000,
    S_SCAN   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (stat.dec_kind)
          abe_pkg::DEC_BIT:  state_next = S_RMW;
          abe_pkg::DEC_SCAN: state_next = S_SCAN;
          default:           state_next = S_RESULT;
        endcase
      end
      S_RMW: begin
        cmd.rmw    = 1'b1;
        state_next = S_RESULT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_room) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/allocation_bitmap_engine_top.sv
// top level of the first-fit allocation bitmap engine
//
//  channel   signals                      direction  moves
//  request   req_valid, req_stall, req    in         operation, bit_index, hole_length
//  response  rsp_valid, rsp_stall, rsp    out        status, bit_value, found_index
//  config    cfg_write, cfg_data          in         bytes_in_use
//
// one request at a time; a search reads n bytes, where n is the number of bytes
// scanned (at most the bytes in use), one ram read per cycle over the bitmap
// after reset a clearing pass writes zero to every byte with requests stalled;
// configuration writes are taken throughout
// a finished response waits in the output register while the next request is taken;
// a stalled response only holds back the following result, not acceptance
module allocation_bitmap_engine_top #(
  parameter int MAX_BYTES = 128
) (
  input  logic          clk,
  input  logic          rst,
  // configuration
  input  logic          cfg_write,
  input  logic [7:0]    cfg_data,
  // request channel
  input  logic          req_valid,
  output logic          req_stall,
  input  abe_pkg::req_t req,
  // response channel
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output abe_pkg::rsp_t rsp
);

  // command and status between controller and datapath
  abe_pkg::ctl_cmd_t cmd;
  abe_pkg::dp_stat_t stat;

  // sequencer: clearing pass, decode, read-modify-write, byte scan, result hand-off
  abe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // bitmap ram, size register, run counter and output register
  abe_datapath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
